### rtl/core/ljpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ljpf_pkg
// Register indexes, port widths and output saturation for the LJ pair force.
// ----------------------------------------------------------------------------
package ljpf_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODIC  = 3'd6;

	// magnitude plus sign to signed 32-bit, saturating
	function automatic logic [31:0] sat_out(input logic [63:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (mag >= 64'h8000_0000) r = 32'h8000_0000;
			else r = 32'(64'd0 - mag);
		end else begin
			if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = mag[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/ljpf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ljpf_in_if / ljpf_out_if
// Valid/ready channels for pair displacements and pair results.
// ----------------------------------------------------------------------------
interface ljpf_in_if #(parameter int POS_WIDTH = 32);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] dx;
	logic signed [POS_WIDTH-1:0] dy;
	logic signed [POS_WIDTH-1:0] dz;
	logic                        last_pair;

	modport source (output valid, dx, dy, dz, last_pair, input ready);
	modport sink   (input valid, dx, dy, dz, last_pair, output ready);
endinterface

interface ljpf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic signed [31:0] energy_term;
	logic signed [31:0] virial_term;
	logic               in_cutoff;
	logic               pass_end;

	modport source (output valid, force_x, force_y, force_z, energy_term, virial_term,
		in_cutoff, pass_end, input ready);
	modport sink   (input valid, force_x, force_y, force_z, energy_term, virial_term,
		in_cutoff, pass_end, output ready);
endinterface
`default_nettype wire

### rtl/core/lj_pair_force_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lj_pair_force_top
// Lennard-Jones 12-6 truncated and shifted pair force, fixed point.
// ----------------------------------------------------------------------------
// One pair enters per clock while no result is held at the output. The pipe
// depth is set by the two divider pipelines (sigma^2/rr, 65 stages, and the
// force divide by rr, 33 stages), five three-stage multipliers for the powers
// of s and the scaling, five plain stages for wrap, square, distance sum,
// term split and energy, and the output register. A result held at the output
// freezes the whole pipe; pair_in.ready drops only while a finished
// transaction waits there.
// Configuration is to be written only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lj_pair_force_top #(
	parameter int POS_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ljpf_in_if.sink                            pair_in,
	ljpf_out_if.source                         result_out,
	input  wire logic                          cfg_we,
	input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ljpf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ljpf_pkg::*;

	localparam int DW = ((POS_WIDTH > 33) ? POS_WIDTH : 33) + 2;
	localparam logic signed [DW-1:0] D_LIM = DW'(64'sh8000_0000);

	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} ax_t;

	// everything a pair carries down the pipe
	typedef struct packed {
		logic             last;
		logic             inc;
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
		logic [63:0]      rr;
		logic [63:0]      s;
		logic [63:0]      s3;
		logic             tn;
		logic             en_neg;
		logic [63:0]      v;
		logic [31:0]      virial;
		logic [31:0]      energy;
	} item_t;

	localparam int IW = $bits(item_t);

	// ---------------- configuration ----------------
	logic [31:0]      sigma_q, eps_q;
	logic [39:0]      cut_q;
	logic [2:0][31:0] box_q;
	logic             per_q;
	logic [63:0]      sig2_q;
	logic [37:0]      eps48_q;
	logic [33:0]      eps4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= 32'd16777216;
			eps_q    <= 32'd16777216;
			cut_q    <= 40'd21138865;
			box_q[0] <= 32'd167772160;
			box_q[1] <= 32'd167772160;
			box_q[2] <= 32'd167772160;
			per_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIGMA:     sigma_q  <= cfg_data[31:0];
				REG_EPSILON:   eps_q    <= cfg_data[31:0];
				REG_CUTOFF_SQ: cut_q    <= cfg_data[39:0];
				REG_BOX_X:     box_q[0] <= cfg_data[31:0];
				REG_BOX_Y:     box_q[1] <= cfg_data[31:0];
				REG_BOX_Z:     box_q[2] <= cfg_data[31:0];
				REG_PERIODIC:  per_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// derived constants, registered, settle in the cycle after a write
	always_ff @(posedge clk) begin
		sig2_q  <= 64'(sigma_q) * 64'(sigma_q);
		eps48_q <= 38'(eps_q) * 38'd48;
		eps4_q  <= {eps_q, 2'b00};
	end

	// ---------------- stall control ----------------
	logic out_v_q;
	logic en;
	assign en            = !out_v_q || result_out.ready;
	assign pair_in.ready = en;

	// minimum image, single correction, then clamp to +-2^31
	function automatic ax_t wrap_axis(input logic signed [POS_WIDTH-1:0] din,
			input logic [31:0] box, input logic per);
		logic signed [DW-1:0] d, bs, hp, hn;
		ax_t r;
		d  = DW'(din);
		bs = $signed(DW'(box));
		hp = $signed(DW'((33'(box) + 33'd1) >> 1));
		hn = $signed(DW'(box >> 1));
		if (per) begin
			if (d >= hp) d = d - bs;
			else if (d < -hn) d = d + bs;
		end
		if (d > D_LIM) d = D_LIM;
		else if (d < -D_LIM) d = -D_LIM;
		r.neg = d < 0;
		r.mag = r.neg ? 32'(-d) : 32'(d);
		return r;
	endfunction

	// ---------------- S1: wrap ----------------
	logic  v_s1, v_s2, v_s3;
	item_t it_s1, it_s2, it_s3;
	item_t it1_d, it3_d;
	logic [2:0][63:0] sq_s2;
	ax_t   ax [3];

	always_comb begin
		ax[0] = wrap_axis(pair_in.dx, box_q[0], per_q);
		ax[1] = wrap_axis(pair_in.dy, box_q[1], per_q);
		ax[2] = wrap_axis(pair_in.dz, box_q[2], per_q);
	end

	always_comb begin
		it1_d      = '0;
		it1_d.last = pair_in.last_pair;
		for (int i = 0; i < 3; i++) begin
			it1_d.neg[i] = ax[i].neg;
			it1_d.mag[i] = ax[i].mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) it_s1 <= it1_d;
	end

	// ---------------- S2: squares ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			for (int i = 0; i < 3; i++) sq_s2[i] <= 64'(it_s1.mag[i]) * 64'(it_s1.mag[i]);
		end
	end

	// ---------------- S3: rr and cutoff test ----------------
	logic [63:0] rr_sum;
	assign rr_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_comb begin
		it3_d     = it_s2;
		it3_d.inc = rr_sum < {cut_q, 24'd0};
		// coincident pair counts as one LSB
		it3_d.rr  = (rr_sum == 64'd0) ? 64'd1 : rr_sum;
	end

	always_ff @(posedge clk) begin
		if (en) it_s3 <= it3_d;
	end

	// ---------------- s = sigma^2 / rr ----------------
	logic        d1_v, d1_sat;
	logic [63:0] d1_q;
	item_t       d1_it, m1_in;

	ljpf_div #(.NW(96), .QW(64), .SIDE_W(IW)) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.num({sig2_q, 32'd0}), .den(it_s3.rr), .side_in(it_s3),
		.out_v(d1_v), .q(d1_q), .sat(d1_sat), .side_out(d1_it)
	);

	always_comb begin
		m1_in   = d1_it;
		m1_in.s = d1_sat ? '1 : d1_q;
	end

	// ---------------- powers of s ----------------
	logic        m1_v, m2_v, m3_v;
	logic [63:0] m1_ps, m2_ps, m3_ps;
	item_t       m1_it, m2_it, m3_in, m3_it;

	ljpf_mul #(.SH(32), .SIDE_W(IW)) u_mul_s2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(d1_v),
		.a(m1_in.s), .b(m1_in.s), .side_in(m1_in),
		.out_v(m1_v), .p(), .ps(m1_ps), .side_out(m1_it)
	);

	ljpf_mul #(.SH(32), .SIDE_W(IW)) u_mul_s3 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(m1_v),
		.a(m1_ps), .b(m1_it.s), .side_in(m1_it),
		.out_v(m2_v), .p(), .ps(m2_ps), .side_out(m2_it)
	);

	always_comb begin
		m3_in    = m2_it;
		m3_in.s3 = m2_ps;
	end

	ljpf_mul #(.SH(32), .SIDE_W(IW)) u_mul_s6 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(m2_v),
		.a(m2_ps), .b(m2_ps), .side_in(m3_in),
		.out_v(m3_v), .p(), .ps(m3_ps), .side_out(m3_it)
	);

	// ---------------- S4: s^6 - s^3/2 and s^6 - s^3 ----------------
	logic        v_s4;
	logic [63:0] tm_s4, em_s4, half_s3;
	item_t       it_s4, it4_d;
	assign half_s3 = m3_it.s3 >> 1;

	always_comb begin
		it4_d        = m3_it;
		it4_d.tn     = m3_ps < half_s3;
		it4_d.en_neg = m3_ps < m3_it.s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= m3_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4 <= it4_d;
			tm_s4 <= (m3_ps >= half_s3) ? m3_ps - half_s3 : half_s3 - m3_ps;
			em_s4 <= (m3_ps >= m3_it.s3) ? m3_ps - m3_it.s3 : m3_it.s3 - m3_ps;
		end
	end

	// ---------------- virial and energy scaling ----------------
	logic        m4_v;
	logic [63:0] m4_ps, m5_ps;
	item_t       m4_it;

	ljpf_mul #(.SH(24), .SIDE_W(IW)) u_mul_vir (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4),
		.a(64'(eps48_q)), .b(tm_s4), .side_in(it_s4),
		.out_v(m4_v), .p(), .ps(m4_ps), .side_out(m4_it)
	);

	ljpf_mul #(.SH(40), .SIDE_W(1)) u_mul_en (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4),
		.a(64'(eps4_q)), .b(em_s4), .side_in(1'b0),
		.out_v(), .p(), .ps(m5_ps), .side_out()
	);

	// ---------------- S5: virial and energy outputs ----------------
	logic               v_s5;
	item_t              it_s5, it5_d;
	logic [40:0]        e_cl;
	logic signed [42:0] e_sum;

	always_comb begin
		e_cl  = (m5_ps > 64'h100_0000_0000) ? 41'h100_0000_0000 : 41'(m5_ps);
		e_sum = (m4_it.en_neg ? -$signed({2'b00, e_cl}) : $signed({2'b00, e_cl}))
			+ $signed(43'(eps_q >> 8));
		it5_d        = m4_it;
		it5_d.v      = m4_ps;
		it5_d.virial = sat_out(m4_ps >> 16, m4_it.tn);
		if (e_sum > 43'sd2147483647) it5_d.energy = 32'h7FFF_FFFF;
		else if (e_sum < -43'sd2147483648) it5_d.energy = 32'h8000_0000;
		else it5_d.energy = e_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= m4_v;
	end

	always_ff @(posedge clk) begin
		if (en) it_s5 <= it5_d;
	end

	// ---------------- force numerators v*|d|*2^8 ----------------
	logic          m6_v;
	logic [127:0]  m6_p [3];
	item_t         m6_it;

	ljpf_mul #(.SH(32), .SIDE_W(IW)) u_mul_fx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s5),
		.a(it_s5.v), .b(64'(it_s5.mag[0])), .side_in(it_s5),
		.out_v(m6_v), .p(m6_p[0]), .ps(), .side_out(m6_it)
	);

	ljpf_mul #(.SH(32), .SIDE_W(1)) u_mul_fy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s5),
		.a(it_s5.v), .b(64'(it_s5.mag[1])), .side_in(1'b0),
		.out_v(), .p(m6_p[1]), .ps(), .side_out()
	);

	ljpf_mul #(.SH(32), .SIDE_W(1)) u_mul_fz (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s5),
		.a(it_s5.v), .b(64'(it_s5.mag[2])), .side_in(1'b0),
		.out_v(), .p(m6_p[2]), .ps(), .side_out()
	);

	// ---------------- force divide by rr ----------------
	logic        d2_v;
	logic [31:0] d2_q [3];
	logic        d2_sat [3];
	item_t       d2_it;

	ljpf_div #(.NW(104), .QW(32), .SIDE_W(IW)) u_div_fx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(m6_v),
		.num({m6_p[0][95:0], 8'd0}), .den(m6_it.rr), .side_in(m6_it),
		.out_v(d2_v), .q(d2_q[0]), .sat(d2_sat[0]), .side_out(d2_it)
	);

	ljpf_div #(.NW(104), .QW(32), .SIDE_W(1)) u_div_fy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(m6_v),
		.num({m6_p[1][95:0], 8'd0}), .den(m6_it.rr), .side_in(1'b0),
		.out_v(), .q(d2_q[1]), .sat(d2_sat[1]), .side_out()
	);

	ljpf_div #(.NW(104), .QW(32), .SIDE_W(1)) u_div_fz (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(m6_v),
		.num({m6_p[2][95:0], 8'd0}), .den(m6_it.rr), .side_in(1'b0),
		.out_v(), .q(d2_q[2]), .sat(d2_sat[2]), .side_out()
	);

	// ---------------- output register ----------------
	logic [2:0][31:0] force_q;
	logic [31:0]      energy_q, virial_q;
	logic             inc_q, last_q;
	logic [63:0]      fmag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) fmag[i] = d2_sat[i] ? 64'h1_0000_0000 : 64'(d2_q[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= d2_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= d2_it.last;
			inc_q  <= d2_it.inc;
			for (int i = 0; i < 3; i++)
				force_q[i] <= d2_it.inc ? sat_out(fmag[i], d2_it.tn ^ d2_it.neg[i]) : 32'd0;
			energy_q <= d2_it.inc ? d2_it.energy : 32'd0;
			virial_q <= d2_it.inc ? d2_it.virial : 32'd0;
		end
	end

	assign result_out.valid       = out_v_q;
	assign result_out.force_x     = force_q[0];
	assign result_out.force_y     = force_q[1];
	assign result_out.force_z     = force_q[2];
	assign result_out.energy_term = energy_q;
	assign result_out.virial_term = virial_q;
	assign result_out.in_cutoff   = inc_q;
	assign result_out.pass_end    = last_q;

`ifndef SYNTHESIS
	// pairs beyond the cutoff carry no force, energy or virial
	assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.in_cutoff |->
			result_out.force_x == 0 && result_out.force_y == 0 &&
			result_out.force_z == 0 && result_out.energy_term == 0 &&
			result_out.virial_term == 0)
		else $error("nonzero output outside cutoff");

	// a held result freezes the head of the pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(it_s1))
		else $error("pipe advanced during stall");

	// input back-pressure only comes from a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		!pair_in.ready |-> result_out.valid && !result_out.ready)
		else $error("input stalled without output stall");
`endif
endmodule
`default_nettype wire

### rtl/core/ljpf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ljpf_mul
// 64x64 multiplier, three stages: 32x32 partials, sum, shift and saturate.
// ----------------------------------------------------------------------------
module ljpf_mul #(
	parameter int SH     = 32,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [63:0]       a,
	input  wire logic [63:0]       b,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_v,
	output logic [127:0]           p,
	output logic [63:0]            ps,
	output logic [SIDE_W-1:0]      side_out
);
	logic              v_s1, v_s2, v_s3;
	logic [63:0]       p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0]      sum_s2, p_s3;
	logic [63:0]       ps_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1  <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1  <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1  <= 64'(a[63:32]) * 64'(b[63:32]);
			side_s1 <= side_in;
			sum_s2  <= {64'd0, p00_s1} + ({64'd0, p01_s1} << 32)
				+ ({64'd0, p10_s1} << 32) + {p11_s1, 64'd0};
			side_s2 <= side_s1;
			p_s3    <= sum_s2;
			ps_s3   <= ((sum_s2 >> (SH + 64)) != 128'd0) ? '1 : 64'(sum_s2 >> SH);
			side_s3 <= side_s2;
		end
	end

	assign out_v    = v_s3;
	assign p        = p_s3;
	assign ps       = ps_s3;
	assign side_out = side_s3;
endmodule
`default_nettype wire

### rtl/core/ljpf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, one quotient bit per stage, saturation flag
// when the quotient does not fit in QW bits. Denominator must be nonzero.
// ----------------------------------------------------------------------------
module ljpf_div #(
	parameter int NW     = 96,
	parameter int QW     = 64,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [NW-1:0]     num,
	input  wire logic [63:0]       den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_v,
	output logic [QW-1:0]          q,
	output logic                   sat,
	output logic [SIDE_W-1:0]      side_out
);
	localparam int HW = NW - QW;
	localparam int CW = (HW > 64) ? HW : 64;

	logic              v_s    [0:QW];
	logic              sat_s  [0:QW];
	logic [63:0]       r_s    [0:QW];
	logic [63:0]       den_s  [0:QW];
	logic [QW-1:0]     q_s    [0:QW];
	logic [QW-1:0]     lo_s   [0:QW];
	logic [SIDE_W-1:0] side_s [0:QW];

	// entry: upper part becomes the starting remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= 64'(num[NW-1:QW]);
			lo_s[0]   <= num[QW-1:0];
			q_s[0]    <= '0;
			sat_s[0]  <= CW'(num[NW-1:QW]) >= CW'(den);
			den_s[0]  <= den;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [64:0] rem;
		logic        ge;
		assign rem = {r_s[k-1], lo_s[k-1][QW-1]};
		assign ge  = rem >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= v_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]    <= ge ? 64'(rem - {1'b0, den_s[k-1]}) : rem[63:0];
				q_s[k]    <= {q_s[k-1][QW-2:0], ge};
				lo_s[k]   <= lo_s[k-1] << 1;
				sat_s[k]  <= sat_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_v    = v_s[QW];
	assign q        = q_s[QW];
	assign sat      = sat_s[QW];
	assign side_out = side_s[QW];
endmodule
`default_nettype wire

### dv/ljpf_checker.sv
// ----------------------------------------------------------------------------
// ljpf_checker
// Watches the pair and result channels and the register port, predicts the
// LJ pair force for every accepted pair and compares it, field by field,
// with the results in order.
// ----------------------------------------------------------------------------
module ljpf_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ljpf_in_if                                     pair_mon,
	ljpf_out_if                                    res_mon,
	input  wire logic                              cfg_we,
	input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [ljpf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                     errors,
	output int                                     waiting
);
	import ljpf_pkg::*;

	typedef struct packed {
		logic [31:0] force_x;
		logic [31:0] force_y;
		logic [31:0] force_z;
		logic [31:0] energy_term;
		logic [31:0] virial_term;
		logic        in_cutoff;
		logic        pass_end;
	} lj_result_t;

	logic [31:0] sigma_q, eps_q, box_q [3];
	logic [39:0] cutoff_q;
	logic        periodic_q;

	lj_result_t expected_results [$];

	function automatic logic [63:0] clip64(input logic [127:0] x);
		return (x[127:64] != 0) ? {64{1'b1}} : x[63:0];
	endfunction

	// floor(a*b / 2^sh), saturating
	function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return clip64(p >> sh);
	endfunction

	function automatic logic [31:0] to_q16(input logic [63:0] m, input logic neg);
		if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
		return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	function automatic lj_result_t pair_force(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz, input logic lp);
		longint      d [3];
		logic [63:0] mag [3];
		logic [63:0] rr, cut, s, s2, s3, s6, tm, em, v, e;
		logic [127:0] num;
		logic [31:0] fq [3];
		logic        tn, en;
		longint      energy;
		lj_result_t  r;
		d[0] = longint'(px);
		d[1] = longint'(py);
		d[2] = longint'(pz);
		rr = 0;
		r = '0;
		r.pass_end = lp;
		for (int i = 0; i < 3; i++) begin
			// minimum image: one correction at most
			if (periodic_q) begin
				if (d[i] >= longint'(({32'd0, box_q[i]} + 64'd1) >> 1))
					d[i] -= longint'({32'd0, box_q[i]});
				else if (d[i] < -longint'({32'd0, box_q[i]} >> 1))
					d[i] += longint'({32'd0, box_q[i]});
			end
			if (d[i] > 64'sd2147483648) d[i] = 64'sd2147483648;
			if (d[i] < -64'sd2147483648) d[i] = -64'sd2147483648;
			mag[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
			rr += mag[i] * mag[i];
		end
		cut = 64'(cutoff_q) << 24;
		if (!(rr < cut)) return r;
		r.in_cutoff = 1'b1;
		if (rr == 0) rr = 1;
		s2 = 64'(sigma_q) * 64'(sigma_q);
		num = {64'd0, s2} << 32;
		s = clip64(num / {64'd0, rr});
		s2 = mul_trunc(s, s, 32);
		s3 = mul_trunc(s2, s, 32);
		s6 = mul_trunc(s3, s3, 32);
		tn = s6 < (s3 >> 1);
		tm = tn ? (s3 >> 1) - s6 : s6 - (s3 >> 1);
		v = mul_trunc(64'd48 * 64'(eps_q), tm, 24);
		r.virial_term = to_q16(v >> 16, tn);
		for (int i = 0; i < 3; i++) begin
			num = ({64'd0, v} * {64'd0, mag[i]}) << 8;
			fq[i] = to_q16(clip64(num / {64'd0, rr}), tn != (d[i] < 0));
		end
		r.force_x = fq[0];
		r.force_y = fq[1];
		r.force_z = fq[2];
		en = s6 < s3;
		em = en ? s3 - s6 : s6 - s3;
		e = mul_trunc(64'd4 * 64'(eps_q), em, 40);
		if (e > (64'd1 << 40)) e = 64'd1 << 40;
		energy = (en ? -longint'(e) : longint'(e)) + longint'(eps_q >> 8);
		if (energy > 64'sd2147483647) energy = 64'sd2147483647;
		if (energy < -64'sd2147483648) energy = -64'sd2147483648;
		r.energy_term = energy[31:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lj_result_t exp_r;
		if (!arst_n) begin
			sigma_q    <= 32'h0100_0000;
			eps_q      <= 32'h0100_0000;
			cutoff_q   <= 40'd21138865;
			box_q[0]   <= 32'h0A00_0000;
			box_q[1]   <= 32'h0A00_0000;
			box_q[2]   <= 32'h0A00_0000;
			periodic_q <= 1'b1;
			errors     = 0;
			waiting    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				REG_SIGMA:     sigma_q    <= cfg_data[31:0];
				REG_EPSILON:   eps_q      <= cfg_data[31:0];
				REG_CUTOFF_SQ: cutoff_q   <= cfg_data[39:0];
				REG_BOX_X:     box_q[0]   <= cfg_data[31:0];
				REG_BOX_Y:     box_q[1]   <= cfg_data[31:0];
				REG_BOX_Z:     box_q[2]   <= cfg_data[31:0];
				REG_PERIODIC:  periodic_q <= cfg_data[0];
				default: ;
				endcase
			end
			if (pair_mon.valid && pair_mon.ready)
				expected_results.push_back(pair_force(pair_mon.dx, pair_mon.dy,
					pair_mon.dz, pair_mon.last_pair));
			if (res_mon.valid && res_mon.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no pair outstanding");
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("force_x", exp_r.force_x, res_mon.force_x);
					check_field("force_y", exp_r.force_y, res_mon.force_y);
					check_field("force_z", exp_r.force_z, res_mon.force_z);
					check_field("energy_term", exp_r.energy_term, res_mon.energy_term);
					check_field("virial_term", exp_r.virial_term, res_mon.virial_term);
					check_field("in_cutoff", 32'(exp_r.in_cutoff), 32'(res_mon.in_cutoff));
					check_field("pass_end", 32'(exp_r.pass_end), 32'(res_mon.pass_end));
				end
			end
			waiting = expected_results.size();
		end
	end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for lj_pair_force_top: directed pairs at the edges of the wrap,
// cutoff and field ranges, then random pairs over several register settings
// with random stalls on both channels; ljpf_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import ljpf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // > long hold + pipe latency + stalls
	localparam int LONG_HOLD      = 500;   // receiver hold-off, fills the pipe
	localparam int DRAIN_CYCLES   = 140;   // longer than the pipe latency

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int  errors, waiting;
	int  idle_cycles = 0;
	bit  quiet = 0;      // when set, neither side inserts gaps
	bit  hold_req = 0;   // asks the receiver for one long hold-off

	ljpf_in_if #(.POS_WIDTH(32)) pair_ch ();
	ljpf_out_if                  res_ch ();

	always #5 clk = ~clk;

	lj_pair_force_top #(.POS_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n), .pair_in(pair_ch), .result_out(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	ljpf_checker chk (
		.clk(clk), .arst_n(arst_n), .pair_mon(pair_ch), .res_mon(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	initial begin
		pair_ch.valid = 1'b0;
		pair_ch.dx = '0;
		pair_ch.dy = '0;
		pair_ch.dz = '0;
		pair_ch.last_pair = 1'b0;
		res_ch.ready = 1'b0;
	end

	// Watchdog: a stretch of WATCHDOG_LIMIT with no transaction and no register write is fatal
	always @(posedge clk) begin
		if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("lj_pair_force_top regression: fail");
			$finish;
		end
	end

	// Result side: random stall per transaction, plus one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
			end
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	// Offer one pair; valid stays high into the next pair when there is no gap
	task automatic send_pair(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic lp);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			pair_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_ch.valid <= 1'b1;
		pair_ch.dx <= x;
		pair_ch.dy <= y;
		pair_ch.dz <= z;
		pair_ch.last_pair <= lp;
		do @(posedge clk); while (!(pair_ch.valid && pair_ch.ready));
	endtask

	// Sender pause: drop valid and wait until every result is back
	task automatic drain_results();
		pair_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Back-to-back register writes, block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [31:0] sig, input logic [31:0] eps,
			input logic [39:0] cut, input logic [31:0] box, input logic per);
		drain_results();
		write_reg(REG_SIGMA, 40'(sig));
		write_reg(REG_EPSILON, 40'(eps));
		write_reg(REG_CUTOFF_SQ, cut);
		write_reg(REG_BOX_X, 40'(box));
		write_reg(REG_BOX_Y, 40'($urandom_range(0, 1) ? box : $urandom));
		write_reg(REG_BOX_Z, 40'(box));
		write_reg(REG_PERIODIC, (40'({$urandom, $urandom}) & ~40'd1) | 40'(per));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly displacements near sigma, the rest random over the full range
	function automatic logic [31:0] rand_disp(input logic [31:0] sig);
		int unsigned pick, span;
		pick = $urandom_range(0, 9);
		span = (sig[31:30] != 0) ? 32'h7FFF_FFFF : (sig << 1) + 32'h0040_0000;
		if (pick < 7) begin
			return $urandom_range(0, 1) ? $urandom_range(0, span) : -$urandom_range(0, span);
		end
		return $urandom;
	endfunction

	task automatic random_phase(input logic [31:0] sig, input int count, input bit squeeze);
		int burst = 0;
		for (int n = 0; n < count; n++) begin
			// occasional stretches without any idling
			if (burst == 0 && $urandom_range(0, 30) == 0) burst = $urandom_range(10, 40);
			quiet = squeeze || (burst > 0);
			if (burst > 0) burst--;
			send_pair(rand_disp(sig), rand_disp(sig), rand_disp(sig), ($urandom_range(0, 7) == 0));
		end
		quiet = 0;
	endtask

	initial begin
		logic [31:0] s;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at reset settings: sigma 1, box 10, wrap on
		send_pair(32'd0, 32'd0, 32'd0, 1'b0);                       // coincident
		send_pair(32'h0100_0000, 32'd0, 32'd0, 1'b1);               // r = sigma
		send_pair(32'h011F_5000, 32'd0, 32'd0, 1'b0);               // near the well
		send_pair(32'h00E0_0000, 32'h0010_0000, -32'sh0008_0000, 1'b0);
		send_pair(32'h0500_0000, 32'd0, 32'd0, 1'b0);               // exactly box/2
		send_pair(-32'sh0500_0000, 32'd0, 32'd0, 1'b0);             // exactly -box/2
		send_pair(-32'sh0500_0001, 32'd0, 32'd0, 1'b1);             // just below -box/2
		send_pair(32'h09FF_0000, 32'h0A00_0000, 32'hF600_0000, 1'b0); // wraps near zero
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 1'b0);
		send_pair(32'h011F_8000, 32'd0, 32'd0, 1'b0);               // at the cutoff edge
		send_pair(32'h0040_0000, 32'd0, 32'd0, 1'b0);               // strong repulsion

		// Open boundaries, zero sigma, zero box, huge cutoff
		load_regs(32'd0, 32'h0100_0000, 40'hFF_FFFF_FFFF, 32'd0, 1'b0);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 1'b0);
		send_pair(32'h0100_0000, 32'd0, 32'd0, 1'b1);
		send_pair(32'd0, 32'd0, 32'd0, 1'b0);
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_pair(32'd0, 32'd0, 32'd0, 1'b0);                       // coincident, saturating
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 1'b1);
		load_regs(32'h0100_0000, 32'd0, 40'd0, 32'h0A00_0000, 1'b1); // nothing inside
		send_pair(32'd0, 32'd0, 32'd0, 1'b1);
		send_pair(32'h0100_0000, 32'd0, 32'd0, 1'b0);

		// Random phases over several settings
		load_regs(32'h0100_0000, 32'h0100_0000, 40'd21138865, 32'h0A00_0000, 1'b1);
		random_phase(32'h0100_0000, 200, 1'b0);
		// Receiver holds off while pairs keep coming: pipe fills, input stalls
		hold_req = 1;
		random_phase(32'h0100_0000, 250, 1'b1);
		drain_results();
		random_phase(32'h0100_0000, 100, 1'b0);

		load_regs(32'h0080_0000, 32'h0200_0000, 40'h00_0400_0000, 32'h0400_0000, 1'b0);
		random_phase(32'h0080_0000, 220, 1'b0);
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		random_phase(32'h7FFF_FFFF, 200, 1'b0);
		load_regs(32'd0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'h0200_0000, 1'b1);
		random_phase(32'h0100_0000, 150, 1'b0);
		for (int k = 0; k < 4; k++) begin
			s = $urandom_range(32'h0040_0000, 32'h0400_0000);
			load_regs(s, $urandom, {8'($urandom_range(0, 255)), $urandom}, $urandom,
				1'($urandom_range(0, 1)));
			random_phase(s, 200, 1'b0);
		end

		// Wait for the tail, then give the verdict
		pair_ch.valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("lj_pair_force_top regression: pass");
		else
			$display("lj_pair_force_top regression: fail");
		$finish;
	end

endmodule
